>>> hw/rtl/gradient_color_map_assert.svh
// ----------------------------------------------------------------------------
// Gradient color map assertion macros
// Concurrent checks on the clk/rst domain; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_MAP_ASSERT_SVH
`define GRADIENT_COLOR_MAP_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge out of reset.
`define GCM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define GCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GCM_ASSERT(lbl, cond, msg)
`define GCM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// Gradient color map package
// Widths, stop reset values and the request types shared by the pipeline.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int POS_W             = 16;
  localparam int CH_W              = 8;
  localparam int NUM_CH            = 3;
  localparam int STOP_W            = POS_W + NUM_CH * CH_W;
  localparam int PROD_W            = POS_W + CH_W;
  localparam int IN_DATA_W         = 16;
  localparam int OUT_DATA_W        = NUM_CH * CH_W;
  localparam int NUM_CFG_REGS      = 5;
  localparam int CFG_INDEX_W       = 3;
  localparam int MAX_STOPS         = 8;
  localparam int NUM_STOPS_DEFAULT = 5;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES        = CH_W / DIV_BITS_PER_STAGE;

  // Stops past the fifth sit at position 1.0, black.
  localparam logic [STOP_W-1:0] STOP_RESET [MAX_STOPS] = '{
    40'd9306112, 40'd137455716143, 40'd274877972737, 40'd412316885169,
    40'd549755813888, 40'd549755813888, 40'd549755813888, 40'd549755813888
  };

  // Divider request: per-channel numerator magnitude and the shared span.
  typedef struct packed {
    logic [NUM_CH-1:0][PROD_W-1:0] num;
    logic [POS_W-1:0]              den;
    logic [NUM_CH-1:0]             neg;
    logic [NUM_CH-1:0][CH_W-1:0]   c_lo;
    logic                          interp;
    logic                          last;
  } div_req_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] quot;
    logic [NUM_CH-1:0]           rem_nz;
    logic [NUM_CH-1:0]           neg;
    logic [NUM_CH-1:0][CH_W-1:0] c_lo;
    logic                        interp;
    logic                        last;
  } div_rsp_t;

endpackage

>>> hw/rtl/gradient_color_map.sv
// ----------------------------------------------------------------------------
// Gradient color map
// Maps a Q1.15 pixel value to an RGB color over a row of gradient stops.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_axis stream, one pixel value per request, with tlast
// marking the final pixel of a frame. Colors leave on the m_axis stream in
// the same order, one per pixel, tlast copied from the input.
// Stops are written through cfg_we/cfg_index/cfg_data while no pixel is in
// flight; indexes past the last stop are ignored.
// There are eight register stages up to tvalid on the output: stop select
// (loaded at the accepting edge), span and color difference, multiply,
// four divider stages of two quotient bits each, and the output register
// with the floor fix-up. Throughput is one pixel per cycle while the
// receiver does not stall; every stage can then take a new request each
// cycle, and the eight-bit quotient is split over four stages.
// Reset empties the pipeline and loads the default five-stop palette.
// When the receiver stalls, the output holds and stages behind it keep
// filling empty slots; s_axis_tready falls only once every stage is full.
// ----------------------------------------------------------------------------
module gradient_color_map #(
  parameter int NUM_STOPS = gcm_pkg::NUM_STOPS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] pixel_value
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [gcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gcm_pkg::STOP_W-1:0]       cfg_data
);
  import gcm_pkg::*;

  `include "gradient_color_map_assert.svh"

  localparam int CHAN_TOP = STOP_W - POS_W - 1;

  // Stop registers
  logic [STOP_W-1:0] stops [NUM_STOPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops[i] <= STOP_RESET[i];
      end
    end else begin
      for (int i = 0; i < NUM_STOPS; i++) begin
        if (cfg_we && i < NUM_CFG_REGS && cfg_index == CFG_INDEX_W'(i)) begin
          stops[i] <= cfg_data;
        end
      end
    end
  end

  // Handshake chain
  logic s1_vld, s2_vld, s3_vld;
  logic en1, en2, en3, en_out;
  logic div_in_ready, div_out_valid;
  div_rsp_t div_rsp;

  assign en_out        = ~m_axis_tvalid | m_axis_tready;
  assign en3           = ~s3_vld | div_in_ready;
  assign en2           = ~s2_vld | en3;
  assign en1           = ~s1_vld | en2;
  assign s_axis_tready = en1;

  // Stage 1: find the enclosing pair of stops, or the one stop to copy
  logic [POS_W-1:0]     pos [NUM_STOPS];
  logic [POS_W-1:0]     v;
  logic [NUM_STOPS-1:0] first_ge, lo_sel, hi_sel;
  logic                 found, sel_interp;
  logic [STOP_W-1:0]    lo_w, hi_w;

  assign v = s_axis_tdata[POS_W-1:0];

  always_comb begin
    found      = 1'b0;
    first_ge   = '0;
    lo_sel     = '0;
    hi_sel     = '0;
    sel_interp = 1'b0;
    lo_w       = '0;
    hi_w       = '0;
    for (int i = 0; i < NUM_STOPS; i++) begin
      pos[i] = stops[i][STOP_W-1 -: POS_W];
    end
    for (int i = 1; i < NUM_STOPS; i++) begin
      first_ge[i] = (pos[i] >= v) & ~found;
      found       = found | (pos[i] >= v);
    end
    if (v <= pos[0]) begin
      lo_sel[0] = 1'b1;
    end else if (v >= pos[NUM_STOPS-1]) begin
      lo_sel[NUM_STOPS-1] = 1'b1;
    end else begin
      // The stop before the first one at or above the value lies strictly
      // below it, so the span is never zero.
      for (int i = 1; i < NUM_STOPS; i++) begin
        if (first_ge[i]) begin
          if (pos[i] == v) begin
            lo_sel[i] = 1'b1;
          end else begin
            lo_sel[i-1] = 1'b1;
            hi_sel[i]   = 1'b1;
            sel_interp  = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NUM_STOPS; i++) begin
      lo_w = lo_w | ({STOP_W{lo_sel[i]}} & stops[i]);
      hi_w = hi_w | ({STOP_W{hi_sel[i]}} & stops[i]);
    end
  end

  logic [STOP_W-1:0] s1_lo_w, s1_hi_w;
  logic [POS_W-1:0]  s1_v;
  logic              s1_interp, s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en1) begin
      s1_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_axis_tvalid) begin
      s1_lo_w   <= lo_w;
      s1_hi_w   <= hi_w;
      s1_v      <= v;
      s1_interp <= sel_interp;
      s1_last   <= s_axis_tlast;
    end
  end

  // Stage 2: span, offset and per-channel color difference
  logic [POS_W-1:0]              diff, den;
  logic [NUM_CH-1:0][CH_W-1:0]   c_lo, mag;
  logic [NUM_CH-1:0]             neg;
  logic [CH_W:0]                 dc;

  always_comb begin
    diff = s1_v - s1_lo_w[STOP_W-1 -: POS_W];
    den  = s1_hi_w[STOP_W-1 -: POS_W] - s1_lo_w[STOP_W-1 -: POS_W];
    dc   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c_lo[ch] = s1_lo_w[CHAN_TOP - CH_W*ch -: CH_W];
      dc       = {1'b0, s1_hi_w[CHAN_TOP - CH_W*ch -: CH_W]} - {1'b0, c_lo[ch]};
      neg[ch]  = dc[CH_W];
      mag[ch]  = dc[CH_W] ? CH_W'(-dc) : dc[CH_W-1:0];
    end
  end

  logic [POS_W-1:0]            s2_diff, s2_den;
  logic [NUM_CH-1:0][CH_W-1:0] s2_c_lo, s2_mag;
  logic [NUM_CH-1:0]           s2_neg;
  logic                        s2_interp, s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en2) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_vld) begin
      s2_diff   <= diff;
      s2_den    <= den;
      s2_c_lo   <= c_lo;
      s2_mag    <= mag;
      s2_neg    <= neg;
      s2_interp <= s1_interp;
      s2_last   <= s1_last;
    end
  end

  // Stage 3: numerator magnitude per channel
  div_req_t req, s3_req;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      req.num[ch] = PROD_W'(s2_mag[ch]) * PROD_W'(s2_diff);
    end
    req.den    = s2_den;
    req.neg    = s2_neg;
    req.c_lo   = s2_c_lo;
    req.interp = s2_interp;
    req.last   = s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en3) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_vld) begin
      s3_req <= req;
    end
  end

  gcm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_vld),
    .in_ready  (div_in_ready),
    .in_req    (s3_req),
    .out_valid (div_out_valid),
    .out_ready (en_out),
    .out_rsp   (div_rsp)
  );

  // Output stage: a falling color rounds toward minus infinity, so a
  // nonzero remainder takes one more step away from the low stop's color.
  logic [NUM_CH-1:0][CH_W-1:0] color;
  logic [CH_W:0]               q_adj, val;

  always_comb begin
    q_adj = '0;
    val   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      q_adj = {1'b0, div_rsp.quot[ch]}
            + (CH_W+1)'(div_rsp.neg[ch] & div_rsp.rem_nz[ch]);
      val   = div_rsp.neg[ch] ? {1'b0, div_rsp.c_lo[ch]} - q_adj
                              : {1'b0, div_rsp.c_lo[ch]} + q_adj;
      color[ch] = div_rsp.interp ? val[CH_W-1:0] : div_rsp.c_lo[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en_out) begin
      m_axis_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && div_out_valid) begin
      m_axis_tdata <= color;
      m_axis_tlast <= div_rsp.last;
    end
  end

  // Checks
  `GCM_ASSERT(a_span_encloses, !(s2_vld && s2_interp) || (s2_diff < s2_den), "offset outside span")
  `GCM_ASSERT(a_ready_when_empty, s1_vld || s_axis_tready, "input stalled with first stage empty")
  `GCM_ASSERT_NEXT(a_s1_drains, s1_vld && en2 && !(s_axis_tvalid && s_axis_tready), !s1_vld, "first stage kept a request")

endmodule

>>> hw/rtl/gcm_divider.sv
// ----------------------------------------------------------------------------
// Gradient color map divider
// Pipelined restoring divider, three channels in parallel, two quotient bits
// per stage. Each stage holds its request while the next one cannot take it.
// ----------------------------------------------------------------------------
module gcm_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gcm_pkg::div_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output gcm_pkg::div_rsp_t out_rsp
);
  import gcm_pkg::*;

  typedef struct packed {
    logic [NUM_CH-1:0][POS_W-1:0] rem;
    logic [NUM_CH-1:0][CH_W-1:0]  bits;
    logic [POS_W-1:0]             den;
    logic [NUM_CH-1:0]            neg;
    logic [NUM_CH-1:0][CH_W-1:0]  c_lo;
    logic                         interp;
    logic                         last;
  } div_state_t;

  // The low dividend bits shift out of the top of bits while quotient bits
  // shift in at the bottom, so bits holds the quotient after the last stage.
  function automatic div_state_t div_step(div_state_t s);
    div_state_t       n;
    logic [POS_W:0]   t;
    n = s;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        t = {n.rem[ch], n.bits[ch][CH_W-1]};
        n.bits[ch] = {n.bits[ch][CH_W-2:0], 1'b0};
        if (t >= {1'b0, n.den}) begin
          n.rem[ch]     = t[POS_W-1:0] - n.den;
          n.bits[ch][0] = 1'b1;
        end else begin
          n.rem[ch] = t[POS_W-1:0];
        end
      end
    end
    return n;
  endfunction

  div_state_t              st     [DIV_STAGES];
  div_state_t              st_in  [DIV_STAGES];
  div_state_t              init;
  logic [DIV_STAGES-1:0]   vld;
  logic [DIV_STAGES-1:0]   vin;
  logic [DIV_STAGES:0]     en;

  // The numerator is below 256 times the span, so its upper bits start as
  // a remainder that is already smaller than the divisor.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      init.rem[ch]  = in_req.num[ch][PROD_W-1 -: POS_W];
      init.bits[ch] = in_req.num[ch][CH_W-1:0];
    end
    init.den    = in_req.den;
    init.neg    = in_req.neg;
    init.c_lo   = in_req.c_lo;
    init.interp = in_req.interp;
    init.last   = in_req.last;
  end

  always_comb begin
    en[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
    st_in[0] = div_step(init);
    vin[0]   = in_valid;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = div_step(st[k-1]);
      vin[k]   = vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k] && vin[k]) begin
        st[k] <= st_in[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[DIV_STAGES-1];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      out_rsp.quot[ch]   = st[DIV_STAGES-1].bits[ch];
      out_rsp.rem_nz[ch] = |st[DIV_STAGES-1].rem[ch];
    end
    out_rsp.neg    = st[DIV_STAGES-1].neg;
    out_rsp.c_lo   = st[DIV_STAGES-1].c_lo;
    out_rsp.interp = st[DIV_STAGES-1].interp;
    out_rsp.last   = st[DIV_STAGES-1].last;
  end

endmodule
